### design/metadata_frame_reassembly_defines.svh
// ----------------------------------------------------------------------------
// Metadata frame reassembly assertion macros
// Shared helpers for the concurrent checks of the reassembly block.
// ----------------------------------------------------------------------------
`ifndef METADATA_FRAME_REASSEMBLY_DEFINES_SVH
`define METADATA_FRAME_REASSEMBLY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mfr_pkg.sv
// ----------------------------------------------------------------------------
// Metadata frame reassembly package
// Types, register indexes and constants shared by the reassembly modules.
// ----------------------------------------------------------------------------
package mfr_pkg;

  localparam int unsigned SidW    = 32;
  localparam int unsigned SeqW    = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned LenW    = 16;
  localparam int unsigned NowW    = 64;
  localparam int unsigned CountW  = 24;
  localparam int unsigned LimitW  = 24;
  localparam int unsigned DlMsW   = 20;
  localparam int unsigned DlUsW   = 30;
  localparam int unsigned MsToUs  = 1000;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned InDataW  = 160;
  localparam int unsigned OutDataW = 112;

  localparam logic [LimitW-1:0] WireLimitRst     = 24'd65536;
  localparam logic [LimitW-1:0] InflatedLimitRst = 24'd1048576;
  localparam logic [DlUsW-1:0]  DeadlineUsRst    = 30'd1000000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIRE_LIMIT      = 2'd0,
    CFG_INFLATED_LIMIT  = 2'd1,
    CFG_EXPIRY_MS       = 2'd2,
    CFG_COMPRESSED_MODE = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_MORE  = 2'd0,
    ST_GAP   = 2'd1,
    ST_LIMIT = 2'd2,
    ST_DONE  = 2'd3
  } status_e;

  typedef struct packed {
    logic [SidW-1:0]  stream_id;
    logic [SeqW-1:0]  seq_num;
    logic [TimeW-1:0] media_time;
    logic             end_marker;
    logic [LenW-1:0]  payload_len;
    logic [NowW-1:0]  now_us;
  } item_t;

  typedef struct packed {
    logic [LimitW-1:0] wire_limit;
    logic [LimitW-1:0] inflated_limit;
    logic [DlUsW-1:0]  deadline_us;
    logic              compressed_mode;
  } cfg_t;

  typedef struct packed {
    status_e           status;
    logic              accept_payload;
    logic              needs_inflate;
    logic [CountW-1:0] frame_length;
    logic [SeqW-1:0]   frame_first_seq;
    logic [TimeW-1:0]  frame_first_time;
    logic [TimeW-1:0]  frame_last_time;
  } result_t;

endpackage

### design/mfr_core.sv
// ----------------------------------------------------------------------------
// Metadata frame reassembly core
// Holds the frame tracking state and computes the result of one item.
// ----------------------------------------------------------------------------
module mfr_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  mfr_pkg::item_t  item_i,
  input  mfr_pkg::cfg_t   cfg_i,
  output mfr_pkg::result_t result_o
);
  import mfr_pkg::*;

  logic              seq_valid_q, seq_valid_d;
  logic [SidW-1:0]   last_stream_q, last_stream_d;
  logic [SeqW-1:0]   last_seq_q, last_seq_d;
  logic              in_frame_q, in_frame_d;
  logic              dropping_q, dropping_d;
  logic [CountW-1:0] byte_count_q, byte_count_d;
  logic [SeqW-1:0]   first_seq_q, first_seq_d;
  logic [TimeW-1:0]  first_time_q, first_time_d;
  logic [TimeW-1:0]  last_time_q, last_time_d;
  logic [NowW-1:0]   start_us_q, start_us_d;

  logic [NowW-1:0]   elapsed;
  logic              expired;
  logic              dup;
  logic              gap;
  logic              handled;
  logic [CountW:0]   sum;
  status_e           status;
  logic              accept;
  logic              inflate;

  assign elapsed = item_i.now_us - start_us_q;
  assign expired = in_frame_q && ($signed(item_i.now_us) > $signed(start_us_q))
                   && (elapsed > NowW'(cfg_i.deadline_us));
  assign dup = seq_valid_q && (last_stream_q == item_i.stream_id)
               && (last_seq_q == item_i.seq_num);
  assign gap = seq_valid_q && ((last_stream_q != item_i.stream_id)
               || (SeqW'(last_seq_q + 1'b1) != item_i.seq_num));

  always_comb begin
    seq_valid_d   = seq_valid_q;
    last_stream_d = last_stream_q;
    last_seq_d    = last_seq_q;
    in_frame_d    = in_frame_q;
    dropping_d    = dropping_q;
    byte_count_d  = byte_count_q;
    first_seq_d   = first_seq_q;
    first_time_d  = first_time_q;
    last_time_d   = last_time_q;
    start_us_d    = start_us_q;
    status        = ST_MORE;
    accept        = 1'b0;
    inflate       = 1'b0;
    handled       = 1'b0;
    sum           = '0;

    if (expired) begin
      in_frame_d   = 1'b0;
      dropping_d   = 1'b1;
      byte_count_d = '0;
      status       = ST_LIMIT;
    end

    if (dup) begin
      status  = ST_MORE;
      handled = 1'b1;
    end else begin
      if (gap) begin
        in_frame_d   = 1'b0;
        dropping_d   = 1'b1;
        byte_count_d = '0;
        status       = ST_GAP;
      end
      last_stream_d = item_i.stream_id;
      last_seq_d    = item_i.seq_num;
      seq_valid_d   = 1'b1;
      if (dropping_d) begin
        if (item_i.end_marker) begin
          dropping_d = 1'b0;
        end
        handled = 1'b1;
      end
    end

    if (!handled) begin
      if (!in_frame_d) begin
        in_frame_d   = 1'b1;
        byte_count_d = '0;
        first_seq_d  = item_i.seq_num;
        first_time_d = item_i.media_time;
        start_us_d   = item_i.now_us;
      end
      last_time_d = item_i.media_time;
      sum = {1'b0, byte_count_d} + (CountW+1)'(item_i.payload_len);
      if (sum > {1'b0, cfg_i.wire_limit}) begin
        in_frame_d   = 1'b0;
        dropping_d   = !item_i.end_marker;
        byte_count_d = '0;
        status       = ST_LIMIT;
      end else begin
        byte_count_d = sum[CountW-1:0];
        accept       = 1'b1;
        if (!item_i.end_marker) begin
          status = ST_MORE;
        end else begin
          in_frame_d = 1'b0;
          if (cfg_i.compressed_mode) begin
            status  = ST_DONE;
            inflate = 1'b1;
          end else if (byte_count_d > cfg_i.inflated_limit) begin
            status = ST_LIMIT;
          end else begin
            status = ST_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_valid_q   <= 1'b0;
      last_stream_q <= '0;
      last_seq_q    <= '0;
      in_frame_q    <= 1'b0;
      dropping_q    <= 1'b0;
      byte_count_q  <= '0;
      first_seq_q   <= '0;
      first_time_q  <= '0;
      last_time_q   <= '0;
      start_us_q    <= '0;
    end else if (step_i) begin
      seq_valid_q   <= seq_valid_d;
      last_stream_q <= last_stream_d;
      last_seq_q    <= last_seq_d;
      in_frame_q    <= in_frame_d;
      dropping_q    <= dropping_d;
      byte_count_q  <= byte_count_d;
      first_seq_q   <= first_seq_d;
      first_time_q  <= first_time_d;
      last_time_q   <= last_time_d;
      start_us_q    <= start_us_d;
    end
  end

  assign result_o.status           = status;
  assign result_o.accept_payload   = accept;
  assign result_o.needs_inflate    = inflate;
  assign result_o.frame_length     = byte_count_d;
  assign result_o.frame_first_seq  = first_seq_d;
  assign result_o.frame_first_time = first_time_d;
  assign result_o.frame_last_time  = last_time_d;

endmodule

### design/metadata_frame_reassembly.sv
// ----------------------------------------------------------------------------
// Metadata frame reassembly
// Tracks marker-delimited frames of packet descriptors and reports status.
// ----------------------------------------------------------------------------
// An item is registered at the input, and its result again at the output.
// Throughput: one item per cycle unless the output stalls.
// When both registers are full, the input ready follows the output ready.
// Reset clears all frame state and returns the registers to their defaults.
`include "metadata_frame_reassembly_defines.svh"

module metadata_frame_reassembly (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mfr_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [mfr_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // stream_id, seq_num, media_time, payload_len, now_us
  input  logic [mfr_pkg::InDataW-1:0]       s_axis_tdata_i,
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // accept_payload, needs_inflate, frame_length, frame_first_seq,
  // frame_first_time, frame_last_time, zero padding
  output logic [mfr_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // status
  output logic [1:0]                        m_axis_tuser_o
);
  import mfr_pkg::*;

  cfg_t    cfg_q;
  item_t   item_q;
  logic    in_valid_q;
  result_t res_q;
  result_t res_d;
  logic    out_valid_q;
  logic    step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wire_limit      <= WireLimitRst;
      cfg_q.inflated_limit  <= InflatedLimitRst;
      cfg_q.deadline_us     <= DeadlineUsRst;
      cfg_q.compressed_mode <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIRE_LIMIT:      cfg_q.wire_limit <= cfg_wdata_i[LimitW-1:0];
        CFG_INFLATED_LIMIT:  cfg_q.inflated_limit <= cfg_wdata_i[LimitW-1:0];
        CFG_EXPIRY_MS:       cfg_q.deadline_us <=
                               DlUsW'(cfg_wdata_i[DlMsW-1:0]) * DlUsW'(MsToUs);
        CFG_COMPRESSED_MODE: cfg_q.compressed_mode <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign step            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q.stream_id   <= s_axis_tdata_i[31:0];
      item_q.seq_num     <= s_axis_tdata_i[47:32];
      item_q.media_time  <= s_axis_tdata_i[79:48];
      item_q.payload_len <= s_axis_tdata_i[95:80];
      item_q.now_us      <= s_axis_tdata_i[159:96];
      item_q.end_marker  <= s_axis_tlast_i;
    end
  end

  mfr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_q.status;
  assign m_axis_tdata_o  = {6'd0, res_q.frame_last_time, res_q.frame_first_time,
                            res_q.frame_first_seq, res_q.frame_length,
                            res_q.needs_inflate, res_q.accept_payload};

  `MFR_ASSERT_SAME(a_inflate_only_done, out_valid_q && res_q.needs_inflate, res_q.status == ST_DONE, "needs_inflate without frame done")
  `MFR_ASSERT_SAME(a_gap_no_accept, out_valid_q && (res_q.status == ST_GAP), !res_q.accept_payload, "payload accepted on a gap")
  `MFR_ASSERT_NEXT(a_step_gives_result, step, out_valid_q, "processed item produced no result")

endmodule

### bench/metadata_frame_reassembly_tb.sv
// ----------------------------------------------------------------------------
// Metadata frame reassembly testbench
// Drives packet descriptors into the reassembly block under several register
// settings, predicts every result in a scoreboard and compares them field by
// field, with random idling on both stream sides and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module metadata_frame_reassembly_tb;
  import mfr_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned PhaseItems = 55;
  localparam int unsigned NumPhases = 10;

  class frame_scoreboard;
    logic [LimitW-1:0] wire_limit;
    logic [LimitW-1:0] inflated_limit;
    logic [DlMsW-1:0]  expiry_ms;
    logic              compressed;

    logic              seq_valid;
    logic [SidW-1:0]   last_stream;
    logic [SeqW-1:0]   last_seq;
    logic              in_frame;
    logic              dropping;
    logic [CountW-1:0] byte_count;
    logic [SeqW-1:0]   first_seq;
    logic [TimeW-1:0]  first_time;
    logic [TimeW-1:0]  last_time;
    logic [NowW-1:0]   start_us;

    result_t pending_q[$];
    int errors;
    int checked;
    int n_done;
    int n_gap;
    int n_limit;

    function void clear();
      wire_limit = WireLimitRst;
      inflated_limit = InflatedLimitRst;
      expiry_ms = 20'd1000;
      compressed = 1'b0;
      seq_valid = 1'b0;
      last_stream = '0;
      last_seq = '0;
      in_frame = 1'b0;
      dropping = 1'b0;
      byte_count = '0;
      first_seq = '0;
      first_time = '0;
      last_time = '0;
      start_us = '0;
      pending_q.delete();
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
      case (idx)
        CFG_WIRE_LIMIT: wire_limit = value;
        CFG_INFLATED_LIMIT: inflated_limit = value;
        CFG_EXPIRY_MS: expiry_ms = value[DlMsW-1:0];
        CFG_COMPRESSED_MODE: compressed = value[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void drop_frame();
      in_frame = 1'b0;
      dropping = 1'b1;
      byte_count = '0;
    endfunction

    function void note_packet(item_t p);
      result_t r;
      status_e st;
      logic accept;
      logic inflate;
      bit handled;
      logic [NowW-1:0] lifetime;
      st = ST_MORE;
      accept = 1'b0;
      inflate = 1'b0;
      handled = 1'b0;
      lifetime = 64'(expiry_ms) * 64'(MsToUs);

      if (in_frame && ($signed(p.now_us) > $signed(start_us)) &&
          ((p.now_us - start_us) > lifetime)) begin
        drop_frame();
        st = ST_LIMIT;
      end

      if (seq_valid && last_stream == p.stream_id && last_seq == p.seq_num) begin
        st = ST_MORE;
        handled = 1'b1;
      end else begin
        if (seq_valid && (last_stream != p.stream_id ||
                          SeqW'(last_seq + 16'd1) != p.seq_num)) begin
          drop_frame();
          st = ST_GAP;
        end
        last_stream = p.stream_id;
        last_seq = p.seq_num;
        seq_valid = 1'b1;
        if (dropping) begin
          if (p.end_marker) dropping = 1'b0;
          handled = 1'b1;
        end
      end

      if (!handled) begin
        if (!in_frame) begin
          in_frame = 1'b1;
          byte_count = '0;
          first_seq = p.seq_num;
          first_time = p.media_time;
          start_us = p.now_us;
        end
        last_time = p.media_time;
        if (({1'b0, byte_count} + 25'(p.payload_len)) > {1'b0, wire_limit}) begin
          in_frame = 1'b0;
          dropping = !p.end_marker;
          byte_count = '0;
          st = ST_LIMIT;
        end else begin
          byte_count = byte_count + CountW'(p.payload_len);
          accept = 1'b1;
          if (!p.end_marker) begin
            st = ST_MORE;
          end else begin
            in_frame = 1'b0;
            if (compressed) begin
              st = ST_DONE;
              inflate = 1'b1;
            end else if (byte_count > inflated_limit) begin
              st = ST_LIMIT;
            end else begin
              st = ST_DONE;
            end
          end
        end
      end

      case (st)
        ST_DONE: n_done++;
        ST_GAP: n_gap++;
        ST_LIMIT: n_limit++;
        default: ;
      endcase

      r.status = st;
      r.accept_payload = accept;
      r.needs_inflate = inflate;
      r.frame_length = byte_count;
      r.frame_first_seq = first_seq;
      r.frame_first_time = first_time;
      r.frame_last_time = last_time;
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] user, logic [OutDataW-1:0] data);
      result_t want;
      if (pending_q.size() == 0) begin
        $error("result with no packet waiting: status %0d data %h", user, data);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (user !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, user);
        errors++;
      end
      if (data[0] !== want.accept_payload) begin
        $error("accept_payload: expected %0d, got %0d", want.accept_payload, data[0]);
        errors++;
      end
      if (data[1] !== want.needs_inflate) begin
        $error("needs_inflate: expected %0d, got %0d", want.needs_inflate, data[1]);
        errors++;
      end
      if (data[25:2] !== want.frame_length) begin
        $error("frame_length: expected %0d, got %0d", want.frame_length, data[25:2]);
        errors++;
      end
      if (data[41:26] !== want.frame_first_seq) begin
        $error("frame_first_seq: expected %0d, got %0d", want.frame_first_seq,
               data[41:26]);
        errors++;
      end
      if (data[73:42] !== want.frame_first_time) begin
        $error("frame_first_time: expected %0d, got %0d", want.frame_first_time,
               data[73:42]);
        errors++;
      end
      if (data[105:74] !== want.frame_last_time) begin
        $error("frame_last_time: expected %0d, got %0d", want.frame_last_time,
               data[105:74]);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx = '0;
  logic [CfgDataW-1:0]  cfg_wdata = '0;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [InDataW-1:0]   s_data = '0;
  logic                 s_last = 1'b0;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [OutDataW-1:0]  m_data;
  logic [1:0]           m_user;

  frame_scoreboard sb = new();
  bit              calm = 1'b0;
  int              packets_sent = 0;
  int              settings_used = 1;
  int unsigned     cycles = 0;

  logic [SidW-1:0]  cur_sid = '0;
  logic [SeqW-1:0]  cur_seq = '0;
  logic [TimeW-1:0] cur_mt = '0;
  logic [NowW-1:0]  cur_now = '0;

  metadata_frame_reassembly dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("status: fail");
    $finish;
  end

  initial begin
    int hold;
    int burst;
    hold = 0;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (rst_n && m_valid && m_ready) begin
        sb.check_result(m_user, m_data);
        if (sb.checked == 150) hold = 400;
      end
      if (hold > 0) begin
        hold--;
        m_ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        m_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 17) - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  task automatic send_pkt(item_t p);
    s_valid <= 1'b1;
    s_data <= {p.now_us, p.payload_len, p.media_time, p.seq_num, p.stream_id};
    s_last <= p.end_marker;
    do @(posedge clk_i); while (!s_ready);
    sb.note_packet(p);
    packets_sent++;
    cur_sid = p.stream_id;
    cur_seq = p.seq_num;
    cur_mt = p.media_time;
    cur_now = p.now_us;
  endtask

  task automatic pkt(logic [SidW-1:0] sid, logic [SeqW-1:0] seq, logic [TimeW-1:0] mt,
                     logic mark, logic [LenW-1:0] len, logic [NowW-1:0] now);
    item_t p;
    p.stream_id = sid;
    p.seq_num = seq;
    p.media_time = mt;
    p.end_marker = mark;
    p.payload_len = len;
    p.now_us = now;
    send_pkt(p);
  endtask

  task automatic pause(int n);
    s_valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_cfg(logic [LimitW-1:0] wl, logic [LimitW-1:0] il,
                         logic [DlMsW-1:0] dl, logic cm);
    logic [CfgDataW-1:0] vals [4];
    cfg_idx_e idx;
    vals[0] = wl;
    vals[1] = il;
    vals[2] = CfgDataW'(dl);
    vals[3] = CfgDataW'(cm);
    drain();
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_e'(i);
      cfg_we <= 1'b1;
      cfg_idx <= idx;
      cfg_wdata <= vals[i];
      @(posedge clk_i);
      sb.set_reg(idx, vals[i]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic item_t random_pkt();
    item_t p;
    int r;
    r = $urandom_range(0, 99);
    p.stream_id = cur_sid;
    p.seq_num = cur_seq + 16'd1;
    p.media_time = cur_mt + $urandom_range(0, 3000);
    p.end_marker = ($urandom_range(0, 3) == 0);
    p.payload_len = ($urandom_range(0, 4) == 0) ? 16'd0 : LenW'($urandom_range(1, 1500));
    p.now_us = cur_now + 64'($urandom_range(0, 20000));
    if ($urandom_range(0, 9) == 0) p.payload_len = LenW'($urandom);
    if (r < 8) begin
      p.seq_num = cur_seq;
    end else if (r < 14) begin
      p.seq_num = cur_seq + SeqW'($urandom_range(2, 65535));
    end else if (r < 19) begin
      p.stream_id = $urandom;
    end else if (r < 23) begin
      p.now_us = cur_now + {32'h0, $urandom};
    end else if (r < 26) begin
      p.now_us = {$urandom, $urandom};
    end else if (r < 29) begin
      p.stream_id = $urandom;
      p.seq_num = SeqW'($urandom);
      p.media_time = $urandom;
      p.end_marker = 1'($urandom_range(0, 1));
      p.payload_len = LenW'($urandom);
      p.now_us = {$urandom, $urandom};
    end
    return p;
  endfunction

  initial begin
    logic [SidW-1:0] sid;
    item_t p;
    sb.clear();
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings, then with an inflated limit of 100 without and with compressed mode.
    sid = 32'h0;
    pkt(sid, 16'd0, 32'd0, 1'b0, 16'd0, 64'd0);
    pkt(sid, 16'd0, 32'd5, 1'b1, 16'd9, 64'd10);
    pkt(sid, 16'd1, 32'd1, 1'b1, 16'hFFFF, 64'd20);
    pkt(sid, 16'd2, 32'd2, 1'b0, 16'hFFFF, 64'd30);
    pkt(sid, 16'd3, 32'd3, 1'b0, 16'd2, 64'd40);
    pkt(sid, 16'd4, 32'd4, 1'b1, 16'd7, 64'd50);
    pkt(sid, 16'd5, 32'd5, 1'b0, 16'd10, 64'd60);
    pkt(sid, 16'd7, 32'd6, 1'b0, 16'd10, 64'd70);
    pkt(sid, 16'd8, 32'd7, 1'b1, 16'd10, 64'd80);
    sid = 32'hFFFF_FFFF;
    pkt(sid, 16'd9, 32'd8, 1'b1, 16'd10, 64'd90);
    pkt(sid, 16'd10, 32'd1000, 1'b0, 16'd100, 64'd1000);
    pkt(sid, 16'd11, 32'd1001, 1'b0, 16'd100, 64'd1001001);
    pkt(sid, 16'd12, 32'd1002, 1'b1, 16'd100, 64'd1001002);
    pkt(sid, 16'd13, 32'd2000, 1'b0, 16'd50, 64'd5000);
    pkt(sid, 16'd14, 32'd2001, 1'b1, 16'd50, 64'd1005000);
    pkt(sid, 16'd15, 32'hFFFF_FFFF, 1'b0, 16'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    pkt(sid, 16'd16, 32'h8000_0000, 1'b0, 16'd1, 64'h7FFF_FFFF_FFFF_FFFF);
    pkt(sid, 16'd17, 32'h7FFF_FFFF, 1'b1, 16'd1, 64'h7FFF_FFFF_FFFF_FFFF);
    pkt(sid, 16'd18, 32'd3000, 1'b0, 16'd1, 64'd100);
    pkt(sid, 16'd19, 32'd3001, 1'b1, 16'd1, 64'h8000_0000_0000_0000);
    pkt(sid, 16'hFFFF, 32'd3002, 1'b1, 16'd3, 64'd200);
    pkt(sid, 16'd0, 32'd3003, 1'b0, 16'd4, 64'd300);
    pkt(sid, 16'd1, 32'd3004, 1'b1, 16'hFFFF, 64'd400);
    set_cfg(24'd65536, 24'd100, 20'd1000, 1'b0);
    pkt(sid, 16'd2, 32'd3005, 1'b1, 16'd101, 64'd500);
    set_cfg(24'd65536, 24'd100, 20'd1000, 1'b1);
    pkt(sid, 16'd3, 32'd3006, 1'b1, 16'd101, 64'd600);

    // Random part, one register setting per phase.
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: set_cfg(24'd0, 24'd0, 20'd0, 1'b0);
        1: set_cfg(24'hFF_FFFF, 24'hFF_FFFF, 20'd1000000, 1'b1);
        default: set_cfg(LimitW'($urandom_range(0, 40000)), LimitW'($urandom_range(0, 40000)),
                         DlMsW'($urandom_range(0, 60)), 1'($urandom_range(0, 1)));
      endcase
      calm = (ph == NumPhases - 1);
      for (int k = 0; k < PhaseItems; k++) begin
        p = random_pkt();
        if (!calm && $urandom_range(0, 7) == 0) pause($urandom_range(1, 17));
        send_pkt(p);
      end
    end

    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end

    $display("Sent %0d packets under %0d register settings, %0d results checked.",
             packets_sent, settings_used, sb.checked);
    $display("Frames done: %0d, gaps: %0d, limit results: %0d.",
             sb.n_done, sb.n_gap, sb.n_limit);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/mfr_pkg.sv
design/mfr_core.sv
design/metadata_frame_reassembly.sv
bench/metadata_frame_reassembly_tb.sv
